>>> sv/bcs_pkg.sv
// Package for the descending byte chunk sorter.
// Holds sizes, the halt marker bytes and the ordering key function; no dependencies.
package bcs_pkg;

    localparam int CHUNK_BYTES = 64;
    localparam int STORE_DEPTH = 64;
    localparam int IDX_W       = $clog2(STORE_DEPTH);

    localparam logic [7:0] OFF_CHAR_O = 8'h4F;
    localparam logic [7:0] OFF_CHAR_F = 8'h46;

    // Flipping the top bit maps signed order onto unsigned order.
    function automatic logic [7:0] order_key(input logic [7:0] b, input logic signed_order);
        order_key = b ^ {signed_order, 7'b0};
    endfunction

endpackage

>>> sv/bcs_byte_if.sv
// Input channel of the sorter: one data byte with an end-of-chunk marker.
// Depends on nothing.
interface bcs_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       chunk_end;

    modport source (output valid, output data_byte, output chunk_end, input ready);
    modport sink (input valid, input data_byte, input chunk_end, output ready);
endinterface

>>> sv/bcs_sorted_if.sv
// Output channel of the sorter: one sorted byte with a last marker.
// Depends on nothing.
interface bcs_sorted_if;
    logic       valid;
    logic       ready;
    logic [7:0] sorted_byte;
    logic       last_out;

    modport source (output valid, output sorted_byte, output last_out, input ready);
    modport sink (input valid, input sorted_byte, input last_out, output ready);
endinterface

>>> sv/bcs_cfg_if.sv
// Configuration write channel of the sorter: the signed_order bit.
// Depends on nothing.
interface bcs_cfg_if;
    logic valid;
    logic ready;
    logic signed_order;

    modport source (output valid, output signed_order, input ready);
    modport sink (input valid, input signed_order, output ready);
endinterface

>>> sv/byte_chunk_sorter_desc.sv
// Top level of the descending byte chunk sorter.
// Depends on bcs_pkg and the interfaces bcs_byte_if, bcs_sorted_if, bcs_cfg_if.
//
// Usage:
//   din  : one byte per item, chunk_end marks the final byte of a chunk. A chunk
//          also ends on its CHUNK_BYTES-th byte. One byte per cycle while filling.
//   dout : the chunk's bytes in descending order, last_out on the final one.
//   cfg  : signed_order (reset 1); 1 orders bytes as signed, 0 as unsigned.
// Sorting: after a chunk of n bytes ends, din is held off while a selection
//   sort with one compare unit and a one-read-port store runs. Each result
//   scans the unsorted entries through the single read port, then is emitted;
//   a receiver stall holds it.
// A chunk starting with "OFF" (three or more bytes) emits nothing and the block
//   halts: din stays ready and every item is dropped until reset.
// Reset: empty chunk, not halted, signed order. The store is not cleared.
// A stalled receiver holds the current result in its output register; the
//   sequencer waits on it.
module byte_chunk_sorter_desc
    import bcs_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    bcs_byte_if.sink     din,
    bcs_sorted_if.source dout,
    bcs_cfg_if.sink      cfg
);

    typedef enum logic [4:0] {
        S_FILL = 5'b00001,
        S_SCAN = 5'b00010,
        S_WAIT = 5'b00100,
        S_EMIT = 5'b01000,
        S_HALT = 5'b10000
    } state_t;

    state_t             state_reg, state_next;
    logic [IDX_W-1:0]   fill_reg, fill_next;
    logic [IDX_W-1:0]   last_reg, last_next;
    logic [IDX_W-1:0]   i_reg, i_next;
    logic [IDX_W-1:0]   j_reg, j_next;
    logic               off_reg, off_next;
    logic               signed_order_reg;
    logic               pend_vld_reg, pend_vld_next;
    logic [IDX_W-1:0]   pend_idx_reg;
    logic [7:0]         rd_data_reg;
    logic [7:0]         best_reg;
    logic [IDX_W-1:0]   best_idx_reg;
    logic [7:0]         cur_reg;

    logic [7:0]         store_mem [STORE_DEPTH];
    logic               we;
    logic [IDX_W-1:0]   wa;
    logic [7:0]         wd;

    logic               in_fire, out_fire, ends, match_now;

    assign din.ready   = (state_reg == S_FILL) || (state_reg == S_HALT);
    assign cfg.ready   = 1'b1;
    assign dout.valid  = (state_reg == S_EMIT);
    assign dout.sorted_byte = best_reg;
    assign dout.last_out    = (i_reg == last_reg);

    assign in_fire  = din.valid && din.ready;
    assign out_fire = dout.valid && dout.ready;
    assign ends     = din.chunk_end || (fill_reg == IDX_W'(CHUNK_BYTES - 1));

    always_comb
    begin
        match_now = 1'b0;
        if (fill_reg == IDX_W'(0))
        begin
            match_now = (din.data_byte == OFF_CHAR_O);
        end
        else if (fill_reg == IDX_W'(1) || fill_reg == IDX_W'(2))
        begin
            match_now = off_reg && (din.data_byte == OFF_CHAR_F);
        end
        else
        begin
            match_now = off_reg;
        end
    end

    always_comb
    begin
        state_next    = state_reg;
        fill_next     = fill_reg;
        last_next     = last_reg;
        i_next        = i_reg;
        j_next        = j_reg;
        off_next      = off_reg;
        pend_vld_next = 1'b0;
        we            = 1'b0;
        wa            = fill_reg;
        wd            = din.data_byte;
        unique case (state_reg)
            S_FILL:
            begin
                if (in_fire)
                begin
                    we       = 1'b1;
                    off_next = match_now;
                    if (ends)
                    begin
                        fill_next = '0;
                        if ((fill_reg >= IDX_W'(2)) && match_now)
                        begin
                            state_next = S_HALT;
                        end
                        else
                        begin
                            last_next  = fill_reg;
                            i_next     = '0;
                            j_next     = '0;
                            state_next = S_SCAN;
                        end
                    end
                    else
                    begin
                        fill_next = fill_reg + IDX_W'(1);
                    end
                end
            end
            S_SCAN:
            begin
                pend_vld_next = 1'b1;
                if (j_reg == last_reg)
                begin
                    state_next = S_WAIT;
                end
                else
                begin
                    j_next = j_reg + IDX_W'(1);
                end
            end
            S_WAIT:
            begin
                state_next = S_EMIT;
            end
            S_EMIT:
            begin
                if (out_fire)
                begin
                    we = 1'b1;
                    wa = best_idx_reg;
                    wd = cur_reg;
                    if (i_reg == last_reg)
                    begin
                        state_next = S_FILL;
                    end
                    else
                    begin
                        i_next     = i_reg + IDX_W'(1);
                        j_next     = i_reg + IDX_W'(1);
                        state_next = S_SCAN;
                    end
                end
            end
            S_HALT:
            begin
                state_next = S_HALT;
            end
            default:
            begin
                state_next = S_FILL;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_FILL;
            fill_reg         <= '0;
            last_reg         <= '0;
            i_reg            <= '0;
            j_reg            <= '0;
            off_reg          <= 1'b0;
            pend_vld_reg     <= 1'b0;
            signed_order_reg <= 1'b1;
        end
        else
        begin
            state_reg    <= state_next;
            fill_reg     <= fill_next;
            last_reg     <= last_next;
            i_reg        <= i_next;
            j_reg        <= j_next;
            off_reg      <= off_next;
            pend_vld_reg <= pend_vld_next;
            if (cfg.valid && cfg.ready)
            begin
                signed_order_reg <= cfg.signed_order;
            end
        end
    end

    // chunk store: one write, one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            store_mem[wa] <= wd;
        end
        rd_data_reg  <= store_mem[j_reg];
        pend_idx_reg <= j_reg;
    end

    // shared compare unit: running maximum over the scanned entries
    always_ff @(posedge clk)
    begin
        if (pend_vld_reg)
        begin
            if (pend_idx_reg == i_reg)
            begin
                cur_reg      <= rd_data_reg;
                best_reg     <= rd_data_reg;
                best_idx_reg <= pend_idx_reg;
            end
            else if (order_key(rd_data_reg, signed_order_reg) >
                     order_key(best_reg, signed_order_reg))
            begin
                best_reg     <= rd_data_reg;
                best_idx_reg <= pend_idx_reg;
            end
        end
    end

    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        dout.valid |-> !din.ready)
        else $error("input ready while a result is pending");

    a_halt_sticks: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_HALT) |=> (state_reg == S_HALT))
        else $error("left halt without reset");

    a_scan_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCAN) |-> (j_reg >= i_reg && j_reg <= last_reg))
        else $error("scan index out of chunk range");

    a_last_to_fill: assert property (@(posedge clk) disable iff (!rst_n)
        (out_fire && dout.last_out) |=> (state_reg == S_FILL))
        else $error("no return to fill after last result");

endmodule

>>> dv/byte_chunk_sorter_desc_tb.sv
// Testbench for byte_chunk_sorter_desc: drives byte chunks and signed_order writes and
// checks every sorted byte against a predictor that keeps its own chunk copy.
// Depends on bcs_pkg, bcs_byte_if, bcs_sorted_if, bcs_cfg_if and the sorter RTL.
module byte_chunk_sorter_desc_tb;
    import bcs_pkg::*;

    localparam int HOLD_CYCLES  = 300;
    localparam int QUIET_LIMIT  = 5000;
    localparam int DRAIN_CYCLES = 2 * CHUNK_BYTES + 8;

    typedef logic [8:0] item_q_t[$];
    typedef logic [7:0] byte_q_t[$];
    typedef struct packed {
        logic [7:0] value;
        logic       last;
    } sorted_item_t;

    logic clk;
    logic rst_n;

    bcs_byte_if   din_ch();
    bcs_sorted_if dout_ch();
    bcs_cfg_if    cfg_ch();

    byte_chunk_sorter_desc uut (
        .clk   (clk),
        .rst_n (rst_n),
        .din   (din_ch),
        .dout  (dout_ch),
        .cfg   (cfg_ch)
    );

    sorted_item_t sorted_expect[$];
    logic [7:0]   pending_chunk[$];
    logic         model_halted = 1'b0;
    logic         model_signed = 1'b1;

    int  idle_pct = 0;
    int  stall_pct = 0;
    bit  hold_req = 1'b0;
    int  hold_left = 0;
    int  quiet_cycles = 0;
    int  errors = 0;
    int  items_in = 0;
    int  results_seen = 0;
    int  chunks_sorted = 0;

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    function automatic void predict_byte(input logic [7:0] b, input logic e);
        logic [7:0] ordered[$];
        logic [7:0] v;
        int n;
        int j;
        if (model_halted)
            return;
        pending_chunk.push_back(b);
        if (!(e || pending_chunk.size() >= CHUNK_BYTES))
            return;
        ordered = pending_chunk;
        pending_chunk.delete();
        n = ordered.size();
        if (n >= 3 && ordered[0] == OFF_CHAR_O && ordered[1] == OFF_CHAR_F &&
            ordered[2] == OFF_CHAR_F)
        begin
            model_halted = 1'b1;
            return;
        end
        chunks_sorted++;
        for (int i = 1; i < n; i++)
        begin
            v = ordered[i];
            j = i;
            while (j > 0 && (ordered[j-1] ^ {model_signed, 7'b0}) < (v ^ {model_signed, 7'b0}))
            begin
                ordered[j] = ordered[j-1];
                j--;
            end
            ordered[j] = v;
        end
        for (int k = 0; k < n; k++)
            sorted_expect.push_back('{value: ordered[k], last: (k == n - 1)});
    endfunction

    // input side and register writes feed the predictor
    always @(posedge clk)
    begin
        if (rst_n && din_ch.valid && din_ch.ready)
        begin
            items_in++;
            predict_byte(din_ch.data_byte, din_ch.chunk_end);
        end
        if (rst_n && cfg_ch.valid && cfg_ch.ready)
            model_signed = cfg_ch.signed_order;
    end

    always @(posedge clk)
    begin : check_sorted
        sorted_item_t exp_item;
        if (rst_n && dout_ch.valid && dout_ch.ready)
        begin
            results_seen++;
            if (sorted_expect.size() == 0)
            begin
                $error("unexpected item: sorted_byte %02h last_out %b",
                       dout_ch.sorted_byte, dout_ch.last_out);
                errors++;
            end
            else
            begin
                exp_item = sorted_expect.pop_front();
                if (dout_ch.sorted_byte !== exp_item.value)
                begin
                    $error("sorted_byte: expected %02h, got %02h",
                           exp_item.value, dout_ch.sorted_byte);
                    errors++;
                end
                if (dout_ch.last_out !== exp_item.last)
                begin
                    $error("last_out: expected %b, got %b", exp_item.last, dout_ch.last_out);
                    errors++;
                end
            end
        end
    end

    // receiver: random stalls, plus a long hold-off on request
    always @(posedge clk)
    begin
        if (hold_req)
        begin
            hold_req = 1'b0;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            dout_ch.ready <= 1'b0;
        end
        else
            dout_ch.ready <= ($urandom_range(99) >= stall_pct);
    end

    always @(posedge clk)
    begin
        if ((din_ch.valid && din_ch.ready) || (dout_ch.valid && dout_ch.ready) ||
            (cfg_ch.valid && cfg_ch.ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("timeout: no item moved for %0d cycles", QUIET_LIMIT);
            $display("byte_chunk_sorter_desc_tb: FAIL");
            $finish;
        end
    end

    function automatic logic [7:0] random_byte();
        case ($urandom_range(7))
            0: return 8'h00;
            1: return 8'hFF;
            2: return 8'h7F;
            3: return 8'h80;
            4: return ($urandom_range(1) != 0) ? OFF_CHAR_O : OFF_CHAR_F;
            default: return $urandom_range(255);
        endcase
    endfunction

    // mostly short chunks, a few large or full-store ones, some with stray end marks
    function automatic item_q_t random_chunk();
        item_q_t q;
        int kind;
        int n;
        kind = $urandom_range(99);
        if (kind < 80)
            n = $urandom_range(12, 1);
        else if (kind < 92)
            n = $urandom_range(40, 13);
        else
            n = CHUNK_BYTES;
        for (int k = 0; k < n; k++)
            q.push_back({(kind >= 70 && kind < 80 && $urandom_range(3) == 0), random_byte()});
        q[n-1][8] = (n < CHUNK_BYTES) ? 1'b1 : 1'($urandom_range(1));
        // keep the halt marker out of random traffic
        for (int k = 0; k + 2 < n; k++)
            if ((k == 0 || q[k-1][8]) && q[k][7:0] == OFF_CHAR_O &&
                q[k+1][7:0] == OFF_CHAR_F && q[k+2][7:0] == OFF_CHAR_F)
                q[k][7:0] = 8'h00;
        return q;
    endfunction

    task automatic append_chunk(ref item_q_t q, input byte_q_t bytes);
        foreach (bytes[k])
            q.push_back({k == bytes.size() - 1, bytes[k]});
    endtask

    task automatic send_items(input item_q_t items);
        foreach (items[k])
        begin
            if ($urandom_range(99) < idle_pct)
            begin
                din_ch.valid <= 1'b0;
                @(posedge clk);
                while ($urandom_range(99) < idle_pct)
                    @(posedge clk);
            end
            din_ch.valid     <= 1'b1;
            din_ch.chunk_end <= items[k][8];
            din_ch.data_byte <= items[k][7:0];
            @(posedge clk);
            while (!din_ch.ready)
                @(posedge clk);
        end
        din_ch.valid <= 1'b0;
    endtask

    // one edge first so the predictor has seen the final accepted item
    task automatic wait_drain();
        @(posedge clk);
        while (sorted_expect.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_order(input logic sig);
        wait_drain();
        cfg_ch.valid        <= 1'b1;
        cfg_ch.signed_order <= sig;
        @(posedge clk);
        while (!cfg_ch.ready)
            @(posedge clk);
        cfg_ch.valid <= 1'b0;
    endtask

    task automatic test_directed();
        item_q_t q;
        idle_pct = 0;
        stall_pct = 0;
        append_chunk(q, '{8'h80, 8'h7F, 8'h00, 8'hFF});
        append_chunk(q, '{OFF_CHAR_O});
        append_chunk(q, '{OFF_CHAR_O, OFF_CHAR_F});
        append_chunk(q, '{8'h05, 8'h05, 8'h05});
        append_chunk(q, '{OFF_CHAR_F, OFF_CHAR_F, OFF_CHAR_O});
        append_chunk(q, '{OFF_CHAR_O, OFF_CHAR_F, 8'h45});
        send_items(q);
        write_order(1'b0);
        q.delete();
        append_chunk(q, '{8'h80, 8'h7F, 8'h00, 8'hFF, 8'h01});
        append_chunk(q, '{8'hFF, 8'hFF});
        send_items(q);
    endtask

    // 64 bytes without an end mark, then one byte that ends a one-byte chunk
    task automatic test_full_store();
        item_q_t q;
        write_order(1'b1);
        idle_pct = 32;
        stall_pct = 32;
        for (int k = 0; k < CHUNK_BYTES; k++)
            q.push_back({1'b0, random_byte()});
        q.push_back({1'b1, random_byte()});
        send_items(q);
    endtask

    task automatic test_random_phase(input int idle, input int stall, input logic sig,
                                     input int count);
        item_q_t q;
        item_q_t c;
        write_order(sig);
        idle_pct = idle;
        stall_pct = stall;
        while (q.size() < count)
        begin
            c = random_chunk();
            foreach (c[k])
                q.push_back(c[k]);
        end
        send_items(q);
    endtask

    task automatic test_pressure();
        item_q_t q;
        wait_drain();
        idle_pct = 0;
        stall_pct = 0;
        for (int k = 0; k < 16; k++)
            q.push_back({k % 8 == 7, random_byte()});
        hold_req = 1'b1;
        send_items(q);
    endtask

    // halt marker chunk, then traffic that must be dropped
    task automatic test_halt();
        item_q_t q;
        wait_drain();
        idle_pct = 32;
        stall_pct = 32;
        append_chunk(q, '{OFF_CHAR_O, OFF_CHAR_F, OFF_CHAR_F, 8'h21});
        for (int k = 0; k < 8; k++)
            q.push_back({(k % 4 == 3), random_byte()});
        send_items(q);
    endtask

    initial
    begin
        rst_n               = 1'b0;
        din_ch.valid        = 1'b0;
        din_ch.data_byte    = 8'h00;
        din_ch.chunk_end    = 1'b0;
        cfg_ch.valid        = 1'b0;
        cfg_ch.signed_order = 1'b1;
        dout_ch.ready       = 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        test_directed();
        test_full_store();
        test_random_phase(0, 0, 1'b0, 6);
        test_random_phase(77, 0, 1'b1, 6);
        test_random_phase(0, 77, 1'b0, 6);
        test_random_phase(32, 32, 1'b1, 6);
        test_pressure();
        test_halt();
        wait_drain();

        if (sorted_expect.size() != 0)
        begin
            $error("%0d expected items never arrived", sorted_expect.size());
            errors++;
        end
        $display("Covered %0d input items and %0d sorted bytes in %0d chunks,",
                 items_in, results_seen, chunks_sorted);
        $display("both byte orders, full-store chunks, output hold-off and the halt marker.");
        if (errors == 0)
            $display("byte_chunk_sorter_desc_tb: PASS");
        else
            $display("byte_chunk_sorter_desc_tb: FAIL");
        $finish;
    end

endmodule
